[rtl/core/first_fit_aligned_allocator_assert.svh]
// Assertion macros for the first-fit aligned allocator.
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_ASSERT_SVH

// Antecedent holds, so consequent holds in the same cycle.
`define FFA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent holds, so consequent holds in the next cycle.
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/ffa_pkg.sv]
// Shared types and constants of the first-fit aligned allocator.
package ffa_pkg;

  localparam int unsigned StartW = 16;
  localparam int unsigned LenW   = 17;
  localparam int unsigned AlignW = 4;
  localparam int unsigned CalcW  = 20;
  localparam logic [LenW-1:0] PoolCap = 17'h10000;

  typedef struct packed {
    logic [LenW-1:0]   len;
    logic [StartW-1:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_MISMATCH = 3'd5
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

endpackage

[rtl/core/ffa_cell.sv]
// One table cell: holds one block entry and passes it to its neighbor on a shift.
module ffa_cell (
  input  logic            clk_i,
  input  logic            shift_en_i,
  input  ffa_pkg::entry_t d_i,
  output ffa_pkg::entry_t q_o
);
  import ffa_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

[rtl/core/first_fit_aligned_allocator.sv]
// Each request walks the whole cell chain in S_WALK, one full rotation of it, and the
// result is then presented in S_DONE, where it is held until the receiver takes it.
// The chain shifts by one entry per cycle during the walk.
// A new request is taken only after the previous result has been taken.
// Reset clears the block count and the control state; the pool size resets to 65536.
// Table entries have no reset; only entries below the block count are used.
module first_fit_aligned_allocator #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: length [16:0], align_log2 [20:17], free_offset [36:21], zero pad [39:37]
  input  logic [39:0] s_axis_tdata,
  // tuser: cmd [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: alloc_offset [15:0]
  output logic [15:0] m_axis_tdata,
  // tuser: status [2:0]
  output logic [2:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffa_pkg::*;

  localparam int unsigned SW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NXT = (MAX_BLOCKS > 1) ? 1 : 0;

  state_e state_q, state_d;
  logic [LenW-1:0]   pool_bytes_q;
  logic [CW-1:0]     count_q, count_d;
  logic [SW-1:0]     step_q, step_d;
  logic              cmd_q;
  logic [LenW-1:0]   len_q;
  logic [AlignW-1:0] align_q;
  logic [StartW-1:0] foff_q;
  logic [CalcW-1:0]  cur_q, cur_d;
  logic [StartW-1:0] where_q, where_d;
  entry_t            carry_q, carry_d;
  logic              decided_q, decided_d;
  logic              found_q, found_d;
  logic              removing_q, removing_d;

  entry_t cell_q [MAX_BLOCKS];
  entry_t cell_d [MAX_BLOCKS];
  entry_t tail, head, new_entry;
  logic   shift_en;

  logic [LenW-1:0]  limit;
  logic [CalcW-1:0] mask, cand, cand_end;
  logic [CW-1:0]    step_ext;
  logic             active, fit_gap, fit_end;
  status_e          status;

  genvar g;
  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      if (g == MAX_BLOCKS - 1) begin : g_tail
        assign cell_d[g] = tail;
      end else begin : g_mid
        assign cell_d[g] = cell_q[g+1];
      end
      ffa_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (shift_en),
        .d_i        (cell_d[g]),
        .q_o        (cell_q[g])
      );
    end
  endgenerate

  assign pready = 1'b1;
  assign prdata = {{(32 - LenW){1'b0}}, pool_bytes_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_bytes_q <= PoolCap;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      pool_bytes_q <= pwdata[LenW-1:0];
    end
  end

  assign head      = cell_q[0];
  assign new_entry = '{len: len_q, start: cand[StartW-1:0]};
  assign limit     = (pool_bytes_q > PoolCap) ? PoolCap : pool_bytes_q;
  assign mask      = (CalcW'(1) << align_q) - CalcW'(1);
  assign cand      = (cur_q + mask) & ~mask;
  assign cand_end  = cand + CalcW'(len_q);
  assign fit_end   = cand_end <= CalcW'(limit);
  assign fit_gap   = fit_end && (cand_end <= CalcW'(head.start));
  assign step_ext  = CW'(step_q);
  assign active    = (len_q != '0) && (count_q < CW'(MAX_BLOCKS));
  assign shift_en  = (state_q == S_WALK);

  always_comb begin
    if (cmd_q == CMD_ALLOC) begin
      if (len_q == '0) begin
        status = ST_NULL;
      end else if (count_q >= CW'(MAX_BLOCKS)) begin
        status = ST_FULL;
      end else if (decided_q) begin
        status = ST_OK;
      end else begin
        status = ST_NOSPACE;
      end
    end else begin
      if (!found_q) begin
        status = ST_UNKNOWN;
      end else if (removing_q) begin
        status = ST_OK;
      end else begin
        status = ST_MISMATCH;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_DONE);
  assign m_axis_tuser  = status;
  assign m_axis_tdata  = (cmd_q == CMD_ALLOC && status == ST_OK) ? where_q : '0;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    cur_d      = cur_q;
    where_d    = where_q;
    carry_d    = carry_q;
    decided_d  = decided_q;
    found_d    = found_q;
    removing_d = removing_q;
    tail       = head;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d    = S_WALK;
          step_d     = '0;
          cur_d      = '0;
          decided_d  = 1'b0;
          found_d    = 1'b0;
          removing_d = 1'b0;
        end
      end
      S_WALK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (decided_q) begin
            tail    = carry_q;
            carry_d = head;
          end else if (active && step_ext < count_q) begin
            if (fit_gap) begin
              tail      = new_entry;
              carry_d   = head;
              decided_d = 1'b1;
              where_d   = cand[StartW-1:0];
            end else begin
              cur_d = CalcW'(head.start) + CalcW'(head.len);
            end
          end else if (active && step_ext == count_q && fit_end) begin
            tail      = new_entry;
            carry_d   = head;
            decided_d = 1'b1;
            where_d   = cand[StartW-1:0];
          end
        end else begin
          if (removing_q) begin
            tail = cell_q[NXT];
          end else if (!found_q && step_ext < count_q && head.start == foff_q) begin
            found_d = 1'b1;
            if (head.len == len_q) begin
              removing_d = 1'b1;
              tail       = cell_q[NXT];
            end
          end
        end
        step_d = step_q + SW'(1);
        if (step_q == SW'(MAX_BLOCKS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
          if (status == ST_OK) begin
            count_d = (cmd_q == CMD_ALLOC) ? count_q + CW'(1) : count_q - CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      step_q     <= '0;
      decided_q  <= 1'b0;
      found_q    <= 1'b0;
      removing_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      step_q     <= step_d;
      decided_q  <= decided_d;
      found_q    <= found_d;
      removing_q <= removing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    where_q <= where_d;
    carry_q <= carry_d;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q   <= s_axis_tuser;
      len_q   <= s_axis_tdata[16:0];
      align_q <= s_axis_tdata[20:17];
      foff_q  <= s_axis_tdata[36:21];
    end
  end

  `include "first_fit_aligned_allocator_assert.svh"

  `FFA_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(MAX_BLOCKS))
  `FFA_ASSERT_NOW(a_one_side, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid)
  `FFA_ASSERT_NEXT(a_alloc_grows, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tready && cmd_q == CMD_ALLOC && status == ST_OK,
    count_q == $past(count_q) + CW'(1))
  `FFA_ASSERT_NEXT(a_fail_keeps, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tready && status != ST_OK,
    count_q == $past(count_q))

endmodule

[tb/first_fit_aligned_allocator_tb.sv]
// Self-checking testbench of the first-fit aligned allocator with a table-driven directed part.
`timescale 1ns / 100ps
module first_fit_aligned_allocator_tb;
  import ffa_pkg::*;

  localparam int unsigned NumBlocks = 16;
  localparam int unsigned RandItems = 1400;
  localparam int unsigned IdleLimit = 20000;
  localparam logic [2:0] AddrPoolSize = 3'd0;

  typedef struct packed {
    cmd_e        cmd;
    logic [16:0] len;
    logic [3:0]  lg;
    logic [15:0] foff;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] offset;
  } grant_t;

  typedef struct {
    request_t req;
    logic     known;
    grant_t   want;
  } vector_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  first_fit_aligned_allocator #(.MAX_BLOCKS(NumBlocks)) uut (.*);

  // Shadow allocator state.
  logic [16:0] shadow_pool = 17'h10000;
  logic [15:0] live_start[NumBlocks];
  logic [16:0] live_len[NumBlocks];
  int unsigned live_count = 0;

  grant_t pending_grants[$];
  logic   pending_known[$];
  grant_t pending_typed[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic grant_t allocate_or_free(request_t r);
    grant_t g;
    logic [19:0] cur, cand, mask, lim;
    int pos;
    g.status = ST_OK;
    g.offset = '0;
    pos = -1;
    lim = (shadow_pool > 17'h10000) ? 20'h10000 : {3'b0, shadow_pool};
    mask = (20'd1 << r.lg) - 20'd1;
    if (r.cmd == CMD_ALLOC) begin
      if (r.len == 0) begin
        g.status = ST_NULL;
      end else if (live_count >= NumBlocks) begin
        g.status = ST_FULL;
      end else begin
        cur = '0;
        for (int i = 0; i < live_count; i++) begin
          cand = (cur + mask) & ~mask;
          if (pos < 0 && cand + r.len <= live_start[i] && cand + r.len <= lim) begin
            pos = i;
            g.offset = cand[15:0];
          end
          if (pos < 0) cur = live_start[i] + live_len[i];
        end
        if (pos < 0) begin
          cand = (cur + mask) & ~mask;
          if (cand + r.len <= lim) begin
            pos = live_count;
            g.offset = cand[15:0];
          end else begin
            g.status = ST_NOSPACE;
          end
        end
        if (pos >= 0) begin
          for (int k = live_count; k > pos; k--) begin
            live_start[k] = live_start[k-1];
            live_len[k] = live_len[k-1];
          end
          live_start[pos] = g.offset;
          live_len[pos] = r.len;
          live_count++;
        end
      end
    end else begin
      g.status = ST_UNKNOWN;
      for (int i = 0; i < live_count; i++) begin
        if (pos < 0 && live_start[i] == r.foff) begin
          pos = i;
          g.status = (live_len[i] == r.len) ? ST_OK : ST_MISMATCH;
        end
      end
      if (g.status == ST_OK) begin
        for (int k = pos; k + 1 < live_count; k++) begin
          live_start[k] = live_start[k+1];
          live_len[k] = live_len[k+1];
        end
        live_count--;
      end
    end
    return g;
  endfunction

  task automatic write_pool_bytes(logic [16:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrPoolSize;
    pwdata <= {15'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_pool = v;
  endtask

  task automatic send_request(request_t r, logic known, grant_t want);
    grant_t g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.cmd;
    s_axis_tdata <= {3'b0, r.foff, r.lg, r.len};
    do @(posedge clk_i); while (!s_axis_tready);
    g = allocate_or_free(r);
    pending_grants.push_back(g);
    pending_known.push_back(known);
    pending_typed.push_back(want);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (NumBlocks + 4) @(posedge clk_i);
  endtask

  function automatic request_t pick_random();
    request_t r;
    int i;
    r.lg = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 4));
    r.foff = 16'($urandom);
    case ($urandom_range(0, 9))
      0: r.len = 17'($urandom_range(0, 17'h10000));
      1: r.len = 17'($urandom);
      default: r.len = 17'($urandom_range(1, 4096));
    endcase
    r.cmd = ($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE;
    if (r.cmd == CMD_FREE && live_count != 0 && $urandom_range(0, 4) != 0) begin
      i = $urandom_range(0, live_count - 1);
      r.foff = live_start[i];
      r.len = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 3)) : live_len[i];
    end
    return r;
  endfunction

  // Receiver stall pattern and result checker.
  logic [7:0] stall_lfsr = 8'hA5;
  always @(posedge clk_i) begin
    grant_t g;
    stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
    m_axis_tready <= stall_lfsr[7] ? (stall_lfsr[1:0] != 2'b00) : 1'b1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result: status %0d offset %0d", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        g = pending_grants.pop_front();
        if (pending_known.pop_front()) begin
          g = pending_typed.pop_front();
        end else begin
          void'(pending_typed.pop_front());
        end
        if (m_axis_tuser !== g.status) begin
          $error("status: expected %0d, actual %0d", g.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata !== g.offset) begin
          $error("alloc_offset: expected %0d, actual %0d", g.offset, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("** first_fit_aligned_allocator: FAILED **");
      $finish;
    end
  end

  vector_t directed[] = '{
    '{'{CMD_ALLOC, 17'd0, 4'd0, 16'd0}, 1'b1, '{ST_NULL, 16'd0}},
    '{'{CMD_FREE, 17'd4, 4'd15, 16'd0}, 1'b1, '{ST_UNKNOWN, 16'd0}},
    '{'{CMD_ALLOC, 17'd16, 4'd0, 16'hFFFF}, 1'b1, '{ST_OK, 16'd0}},
    '{'{CMD_ALLOC, 17'd1, 4'd15, 16'd0}, 1'b1, '{ST_OK, 16'h8000}},
    '{'{CMD_ALLOC, 17'h10000, 4'd0, 16'd0}, 1'b1, '{ST_NOSPACE, 16'd0}},
    '{'{CMD_ALLOC, 17'h1FFFF, 4'd0, 16'd0}, 1'b1, '{ST_NOSPACE, 16'd0}},
    '{'{CMD_ALLOC, 17'd8, 4'd3, 16'd0}, 1'b0, '{ST_OK, 16'd0}},
    '{'{CMD_FREE, 17'd0, 4'd0, 16'd0}, 1'b1, '{ST_MISMATCH, 16'd0}},
    '{'{CMD_FREE, 17'd15, 4'd0, 16'd0}, 1'b1, '{ST_MISMATCH, 16'd0}},
    '{'{CMD_FREE, 17'd16, 4'd7, 16'd0}, 1'b1, '{ST_OK, 16'd0}},
    '{'{CMD_ALLOC, 17'd4, 4'd2, 16'd0}, 1'b0, '{ST_OK, 16'd0}},
    '{'{CMD_FREE, 17'd1, 4'd0, 16'h8000}, 1'b1, '{ST_OK, 16'd0}},
    '{'{CMD_ALLOC, 17'h8000, 4'd15, 16'd0}, 1'b0, '{ST_OK, 16'd0}}
  };

  initial begin
    request_t r;
    logic [16:0] pools[6] = '{17'd1, 17'd0, 17'h1FFFF, 17'd300, 17'd4096, 17'h10000};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].known, directed[i].want);
    end
    drain();
    // Table full: add one-byte blocks to those left by the directed part until the table is full, and go past it.
    for (int i = 0; i < NumBlocks + 2; i++) begin
      r = '{CMD_ALLOC, 17'd1, 4'd0, 16'd0};
      send_request(r, 1'b0, '{ST_OK, 16'd0});
    end
    drain();
    foreach (pools[p]) begin
      write_pool_bytes(pools[p]);
      for (int n = 0; n < RandItems / 6; n++) begin
        r = pick_random();
        send_request(r, 1'b0, '{ST_OK, 16'd0});
        sender_gap();
      end
      drain();
    end
    if (errors == 0) begin
      $display("** first_fit_aligned_allocator: PASSED **");
    end else begin
      $display("** first_fit_aligned_allocator: FAILED **");
    end
    $finish;
  end

endmodule
